>>> design/jhsp_pkg.sv
// ----------------------------------------------------------------------------
// jhsp_pkg
// Shared types, marker codes and error codes for the JPEG header parser.
// ----------------------------------------------------------------------------
`default_nettype none
package jhsp_pkg;

  localparam int HuffTableDepth = 256;
  localparam int SlotW = $clog2(HuffTableDepth + 1);

  typedef enum logic [4:0] {
    ST_M1, ST_M2, ST_LEN_HI, ST_LEN_LO, ST_SKIP, ST_APP0, ST_DQT_PQ, ST_DQT_VAL,
    ST_SOF, ST_SOF_COMP, ST_DHT_TCTH, ST_DHT_LEN, ST_DHT_SYM, ST_SOS_NS,
    ST_SOS_COMP, ST_SOS_TAIL, ST_ENT, ST_ENT_FF, ST_DEAD
  } pstate_t;

  typedef enum logic [2:0] {
    K_HUFF = 3'd0, K_QUANT = 3'd1, K_FRAME = 3'd2, K_COMP = 3'd3,
    K_SCAN = 3'd4, K_DATA = 3'd5, K_END = 3'd6, K_ERR = 3'd7
  } kind_t;

  localparam logic [7:0] M_SOI  = 8'hD8;
  localparam logic [7:0] M_EOI  = 8'hD9;
  localparam logic [7:0] M_COM  = 8'hFE;
  localparam logic [7:0] M_APP1 = 8'hE1;
  localparam logic [7:0] M_APP0 = 8'hE0;
  localparam logic [7:0] M_DQT  = 8'hDB;
  localparam logic [7:0] M_SOF0 = 8'hC0;
  localparam logic [7:0] M_DHT  = 8'hC4;
  localparam logic [7:0] M_SOS  = 8'hDA;

  localparam logic [15:0] E_MARKER = 16'd1,  E_SHORT = 16'd2,  E_JFIF = 16'd3;
  localparam logic [15:0] E_PQ = 16'd4, E_DQTLEN = 16'd5, E_DQTID = 16'd6;
  localparam logic [15:0] E_PREC = 16'd7, E_HEIGHT = 16'd8, E_NCOMP = 16'd9;
  localparam logic [15:0] E_COMPQ = 16'd10, E_DHTID = 16'd11, E_FULL = 16'd12;
  localparam logic [15:0] E_FIT = 16'd13, E_DHTEND = 16'd14, E_NS = 16'd15;
  localparam logic [15:0] E_SEL = 16'd16, E_ENTMK = 16'd17;

  typedef struct packed {
    logic [2:0]  kind;
    logic        table_class;
    logic [1:0]  table_id;
    logic [7:0]  entry_index;
    logic [4:0]  code_length;
    logic [15:0] codeword;
    logic [15:0] value_a;
    logic [15:0] value_b;
  } result_t;

  function automatic logic [7:0] jfif_char(input logic [2:0] i);
    case (i)
      3'd0:    jfif_char = 8'h4A;
      3'd1:    jfif_char = 8'h46;
      3'd2:    jfif_char = 8'h49;
      3'd3:    jfif_char = 8'h46;
      default: jfif_char = 8'h00;
    endcase
  endfunction

endpackage
`default_nettype wire

>>> design/jhsp_ram.sv
// ----------------------------------------------------------------------------
// jhsp_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module jhsp_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> design/jhsp_parser.sv
// ----------------------------------------------------------------------------
// jhsp_parser
// Byte parser state machine. Length counts live in a RAM that is read one
// entry ahead of the Huffman length walk.
// ----------------------------------------------------------------------------
`default_nettype none
module jhsp_parser
  import jhsp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire logic [7:0] data_byte,
  output logic            walking,
  output logic            res_valid,
  output result_t         res
);
  pstate_t     st_r, st_nxt;
  logic [15:0] seg_r, seg_nxt;
  logic [SlotW-1:0] fill_r [4];
  logic [SlotW-1:0] fill_nxt [4];
  logic [16:0] code_r, code_nxt;
  logic [4:0]  clen_r, clen_nxt;
  logic [7:0]  left_r, left_nxt;
  logic [1:0]  tsel_r, tsel_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  logic [17:0] skip_r, skip_nxt;
  logic [15:0] hw_r, hw_nxt;
  logic [15:0] hw2_r, hw2_nxt;
  // Walk flag: zero lengths still to be skipped before the next symbol.
  logic        walk_r, walk_nxt;

  logic        lc_we;
  logic [3:0]  lc_waddr, lc_raddr;
  logic [7:0]  lc_wdata, lc_rdata;
  logic [7:0]  lc_fwd_r;
  logic        lc_fwd_en_r;
  logic [7:0]  lc_val;

  jhsp_ram #(.Width(8), .Depth(16)) u_lc (
    .clk(clk), .we(lc_we), .waddr(lc_waddr), .wdata(lc_wdata),
    .raddr(lc_raddr), .rdata(lc_rdata)
  );

  assign lc_val  = lc_fwd_en_r ? lc_fwd_r : lc_rdata;
  assign walking = walk_r;

  always_ff @(posedge clk) begin
    lc_fwd_en_r <= lc_we && (lc_waddr == lc_raddr);
    lc_fwd_r    <= lc_wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_M1; seg_r <= '0; code_r <= '0; clen_r <= '0; left_r <= '0;
      tsel_r <= '0; cnt_r <= '0; skip_r <= '0; hw_r <= '0; hw2_r <= '0;
      walk_r <= 1'b0;
      for (int i = 0; i < 4; i++) fill_r[i] <= '0;
    end else begin
      st_r <= st_nxt; seg_r <= seg_nxt; code_r <= code_nxt; clen_r <= clen_nxt;
      left_r <= left_nxt; tsel_r <= tsel_nxt; cnt_r <= cnt_nxt; skip_r <= skip_nxt;
      hw_r <= hw_nxt; hw2_r <= hw2_nxt; walk_r <= walk_nxt;
      for (int i = 0; i < 4; i++) fill_r[i] <= fill_nxt[i];
    end
  end

  logic [3:0]  hi, lo;
  logic [15:0] len;
  logic [7:0]  cnt_inc;
  logic [1:0]  k3;
  logic [7:0]  i3;
  logic [17:0] thumb;
  logic [16:0] lim;
  logic [SlotW-1:0] slot;

  always_comb begin
    hi = data_byte[7:4];
    lo = data_byte[3:0];
    len = {hw_r[15:8], data_byte};
    cnt_inc = cnt_r + 8'd1;
    k3 = cnt_r[1:0];
    i3 = hw2_r[7:0];
    thumb = 18'(3 * 18'(hw_r[7:0]) * 18'(data_byte));
    lim = (17'd1 << clen_r) - 17'd1;
    slot = fill_r[tsel_r];

    st_nxt = st_r; seg_nxt = seg_r; code_nxt = code_r; clen_nxt = clen_r;
    left_nxt = left_r; tsel_nxt = tsel_r; cnt_nxt = cnt_r; skip_nxt = skip_r;
    hw_nxt = hw_r; hw2_nxt = hw2_r; walk_nxt = walk_r;
    for (int i = 0; i < 4; i++) fill_nxt[i] = fill_r[i];
    lc_we = 1'b0; lc_waddr = cnt_r[3:0]; lc_wdata = data_byte;
    lc_raddr = clen_r[3:0];
    res_valid = 1'b0;
    res = '0;

    // Between bytes the length walk moves one length per cycle; through the
    // registered RAM read it fetches the count of length clen_r+1 (address clen_r) ahead.
    if (walk_r && !step) begin
      if (left_r != 8'd0) begin
        walk_nxt = 1'b0;
      end else if (clen_r == 5'd16) begin
        clen_nxt = 5'd17;
        walk_nxt = 1'b0;
      end else begin
        code_nxt = {code_r[15:0], 1'b0};
        clen_nxt = clen_r + 5'd1;
        left_nxt = lc_val;
        lc_raddr = clen_nxt[3:0];
      end
    end

    if (step) begin
      case (st_r)
        ST_M1: begin
          if (data_byte != 8'hFF) begin
            res_valid = 1'b1; res.kind = K_ERR; res.value_a = E_MARKER; st_nxt = ST_DEAD;
          end else st_nxt = ST_M2;
        end
        ST_M2: begin
          if (data_byte == M_SOI) st_nxt = ST_M1;
          else if (data_byte == M_EOI) begin
            st_nxt = ST_M1; res_valid = 1'b1; res.kind = K_END;
          end else if (data_byte == M_COM || data_byte == M_APP1 ||
                       data_byte == M_APP0 || data_byte == M_DQT ||
                       data_byte == M_SOF0 || data_byte == M_DHT ||
                       data_byte == M_SOS) begin
            hw2_nxt = {8'hFF, data_byte}; st_nxt = ST_LEN_HI;
          end else begin
            res_valid = 1'b1; res.kind = K_ERR; res.value_a = E_MARKER; st_nxt = ST_DEAD;
          end
        end
        ST_LEN_HI: begin
          hw_nxt = {data_byte, 8'h00}; st_nxt = ST_LEN_LO;
        end
        ST_LEN_LO: begin
          if (len < 16'd2 || (hw2_r[7:0] == M_APP0 && len < 16'd16)) begin
            res_valid = 1'b1; res.kind = K_ERR; res.value_a = E_SHORT; st_nxt = ST_DEAD;
          end else begin
            case (hw2_r[7:0])
              M_COM, M_APP1: begin
                skip_nxt = 18'(len - 16'd2);
                st_nxt = (len == 16'd2) ? ST_M1 : ST_SKIP;
              end
              M_APP0: begin cnt_nxt = '0; st_nxt = ST_APP0; end
              M_DQT:  begin seg_nxt = len; st_nxt = ST_DQT_PQ; end
              M_SOF0: begin cnt_nxt = '0; st_nxt = ST_SOF; end
              M_DHT: begin
                seg_nxt = len - 16'd2;
                st_nxt = (len == 16'd2) ? ST_M1 : ST_DHT_TCTH;
              end
              default: st_nxt = ST_SOS_NS;
            endcase
          end
        end
        ST_SKIP: begin
          skip_nxt = skip_r - 18'd1;
          if (skip_nxt == '0) st_nxt = ST_M1;
        end
        ST_APP0: begin
          cnt_nxt = cnt_inc;
          if (cnt_r < 8'd5) begin
            if (data_byte != jfif_char(cnt_r[2:0])) begin
              res_valid = 1'b1; res.kind = K_ERR; res.value_a = E_JFIF; st_nxt = ST_DEAD;
            end
          end else if (cnt_r == 8'd12) hw_nxt = {8'h00, data_byte};
          else if (cnt_r == 8'd13) begin
            skip_nxt = thumb;
            st_nxt = (thumb == '0) ? ST_M1 : ST_SKIP;
          end
        end
        ST_DQT_PQ: begin
          res.kind = K_ERR;
          if (hi != 4'd0) begin
            res_valid = 1'b1; res.value_a = E_PQ; st_nxt = ST_DEAD;
          end else if (seg_r != 16'd67) begin
            res_valid = 1'b1; res.value_a = E_DQTLEN; st_nxt = ST_DEAD;
          end else if (lo > 4'd3) begin
            res_valid = 1'b1; res.value_a = E_DQTID; st_nxt = ST_DEAD;
          end else begin
            tsel_nxt = lo[1:0]; cnt_nxt = '0; st_nxt = ST_DQT_VAL;
          end
        end
        ST_DQT_VAL: begin
          cnt_nxt = cnt_inc;
          if (cnt_inc >= 8'd64) st_nxt = ST_M1;
          res_valid = 1'b1; res.kind = K_QUANT; res.table_id = tsel_r;
          res.entry_index = cnt_r; res.value_a = {8'h00, data_byte};
        end
        ST_SOF: begin
          cnt_nxt = cnt_inc;
          res.kind = K_ERR;
          case (cnt_r)
            8'd0: if (data_byte != 8'd8) begin
              res_valid = 1'b1; res.value_a = E_PREC; st_nxt = ST_DEAD;
            end
            8'd1: hw_nxt = {data_byte, 8'h00};
            8'd2: begin
              hw_nxt = {hw_r[15:8], data_byte};
              if (hw_nxt == '0) begin
                res_valid = 1'b1; res.value_a = E_HEIGHT; st_nxt = ST_DEAD;
              end
            end
            8'd3: hw2_nxt = {data_byte, 8'h00};
            8'd4: begin
              res_valid = 1'b1; res.kind = K_FRAME; res.value_a = hw_r;
              res.value_b = {hw2_r[15:8], data_byte};
            end
            default: begin
              if (data_byte != 8'd3) begin
                res_valid = 1'b1; res.value_a = E_NCOMP; st_nxt = ST_DEAD;
              end else begin
                cnt_nxt = '0; hw2_nxt = '0; st_nxt = ST_SOF_COMP;
              end
            end
          endcase
        end
        ST_SOF_COMP: begin
          // cnt_r counts 0..2 within a component, hw2_r counts components
          cnt_nxt = (k3 == 2'd2) ? 8'd0 : cnt_inc;
          if (k3 == 2'd1) hw_nxt = {8'h00, data_byte};
          if (k3 == 2'd2) begin
            if (data_byte > 8'd3) begin
              res_valid = 1'b1; res.kind = K_ERR; res.value_a = E_COMPQ; st_nxt = ST_DEAD;
            end else begin
              hw2_nxt = hw2_r + 16'd1;
              if (i3 == 8'd2) st_nxt = ST_M1;
              res_valid = 1'b1; res.kind = K_COMP; res.table_id = data_byte[1:0];
              res.entry_index = i3; res.value_a = {12'h0, hw_r[7:4]};
              res.value_b = {12'h0, hw_r[3:0]};
            end
          end
        end
        ST_DHT_TCTH: begin
          res.kind = K_ERR;
          if (seg_r == '0) begin
            res_valid = 1'b1; res.value_a = E_DHTEND; st_nxt = ST_DEAD;
          end else begin
            seg_nxt = seg_r - 16'd1;
            if (hi > 4'd1 || lo > 4'd1) begin
              res_valid = 1'b1; res.value_a = E_DHTID; st_nxt = ST_DEAD;
            end else begin
              tsel_nxt = {hi[0], lo[0]};
              fill_nxt[{hi[0], lo[0]}] = '0;
              cnt_nxt = '0; st_nxt = ST_DHT_LEN;
            end
          end
        end
        ST_DHT_LEN: begin
          if (seg_r == '0) begin
            res_valid = 1'b1; res.kind = K_ERR; res.value_a = E_DHTEND; st_nxt = ST_DEAD;
          end else begin
            seg_nxt = seg_r - 16'd1;
            lc_we = 1'b1;
            cnt_nxt = cnt_inc;
            if (cnt_r[3:0] == 4'd0) left_nxt = data_byte;
            if (cnt_inc >= 8'd16) begin
              code_nxt = '0; clen_nxt = 5'd1; walk_nxt = 1'b1;
              lc_raddr = 4'd1;
              st_nxt = ST_DHT_SYM;
            end
          end
        end
        ST_DHT_SYM: begin
          // walk is done here: left_r nonzero or clen_r == 17
          if (clen_r == 5'd17) begin
            // table has no codes left; re-dispatch byte as next state
            if (seg_r == '0) begin
              res_valid = 1'b1; res.kind = K_ERR; res.value_a = E_MARKER;
              st_nxt = ST_DEAD;
              if (data_byte == 8'hFF) begin
                res_valid = 1'b0; st_nxt = ST_M2;
              end
            end else begin
              seg_nxt = seg_r - 16'd1;
              res.kind = K_ERR;
              if (hi > 4'd1 || lo > 4'd1) begin
                res_valid = 1'b1; res.value_a = E_DHTID; st_nxt = ST_DEAD;
              end else begin
                tsel_nxt = {hi[0], lo[0]};
                fill_nxt[{hi[0], lo[0]}] = '0;
                cnt_nxt = '0; st_nxt = ST_DHT_LEN;
              end
            end
          end else if (seg_r == '0) begin
            res_valid = 1'b1; res.kind = K_ERR; res.value_a = E_DHTEND; st_nxt = ST_DEAD;
          end else begin
            seg_nxt = seg_r - 16'd1;
            res.kind = K_ERR;
            if (32'(slot) >= HuffTableDepth) begin
              res_valid = 1'b1; res.value_a = E_FULL; st_nxt = ST_DEAD;
            end else if (code_r > lim) begin
              res_valid = 1'b1; res.value_a = E_FIT; st_nxt = ST_DEAD;
            end else begin
              fill_nxt[tsel_r] = slot + SlotW'(1);
              code_nxt = code_r + 17'd1;
              left_nxt = left_r - 8'd1;
              walk_nxt = (left_r == 8'd1);
              res_valid = 1'b1; res.kind = K_HUFF; res.table_class = tsel_r[1];
              res.table_id = {1'b0, tsel_r[0]}; res.entry_index = slot[7:0];
              res.code_length = clen_r; res.codeword = code_r[15:0];
              res.value_a = {8'h00, data_byte};
            end
          end
        end
        ST_SOS_NS: begin
          if (data_byte == 8'd0 || data_byte > 8'd4) begin
            res_valid = 1'b1; res.kind = K_ERR; res.value_a = E_NS; st_nxt = ST_DEAD;
          end else begin
            hw_nxt = {8'h00, data_byte}; cnt_nxt = '0; st_nxt = ST_SOS_COMP;
          end
        end
        ST_SOS_COMP: begin
          cnt_nxt = cnt_inc;
          if ({8'h00, cnt_inc} >= {hw_r[14:0], 1'b0}) begin
            cnt_nxt = '0; st_nxt = ST_SOS_TAIL;
          end
          if (cnt_r[0]) begin
            if (hi > 4'd1 || lo > 4'd1) begin
              res_valid = 1'b1; res.kind = K_ERR; res.value_a = E_SEL; st_nxt = ST_DEAD;
            end else begin
              res_valid = 1'b1; res.kind = K_SCAN; res.entry_index = {1'b0, cnt_r[7:1]};
              res.value_a = {12'h0, hi}; res.value_b = {12'h0, lo};
            end
          end
        end
        ST_SOS_TAIL: begin
          cnt_nxt = cnt_inc;
          if (cnt_inc >= 8'd3) st_nxt = ST_ENT;
        end
        ST_ENT: begin
          if (data_byte == 8'hFF) st_nxt = ST_ENT_FF;
          else begin
            res_valid = 1'b1; res.kind = K_DATA; res.value_a = {8'h00, data_byte};
          end
        end
        ST_ENT_FF: begin
          res_valid = 1'b1;
          if (data_byte == 8'h00) begin
            st_nxt = ST_ENT; res.kind = K_DATA; res.value_a = 16'h00FF;
          end else if (data_byte == M_EOI) begin
            st_nxt = ST_M1; res.kind = K_END;
          end else begin
            res.kind = K_ERR; res.value_a = E_ENTMK; st_nxt = ST_DEAD;
          end
        end
        default: st_nxt = ST_DEAD;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> design/jpeg_header_and_stuffing_parser_core.sv
// ----------------------------------------------------------------------------
// jpeg_header_and_stuffing_parser_core
// Baseline JPEG marker parser with entropy byte unstuffing.
// ----------------------------------------------------------------------------
// channel | dir | payload
// in_     | in  | tdata[7:0] data_byte
// out_    | out | tdata[71:0] packed result fields
// One byte per cycle unless stalled. After the last DHT length count, and
// after each symbol whose length is exhausted, the code-length walk moves one
// length per cycle through the length-count RAM; in_tready is low while it
// runs or on output back-pressure. Sync reset clears all control state. The
// output register takes a new request while the old one is being taken.
// ----------------------------------------------------------------------------
`default_nettype none
module jpeg_header_and_stuffing_parser_core
  import jhsp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // data_byte[7:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [71:0]      out_tdata   // kind, table_class, table_id,
                                       // entry_index, code_length,
                                       // codeword, value_a, value_b
);
  logic    step, res_valid, walking;
  result_t res, out_r;
  logic    ov_r;

  assign in_tready = (!ov_r || out_tready) && !walking;
  assign step      = in_tvalid && in_tready;

  jhsp_parser u_parser (
    .clk(clk), .rst_n(rst_n), .step(step), .data_byte(in_tdata),
    .walking(walking), .res_valid(res_valid), .res(res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (step) ov_r <= res_valid;
    else if (out_tready) ov_r <= 1'b0;
    if (step && res_valid) out_r <= res;
  end

  assign out_tvalid = ov_r;
  assign out_tdata = {5'b0, out_r.value_b, out_r.value_a, out_r.codeword,
                      out_r.code_length, out_r.entry_index, out_r.table_id,
                      out_r.table_class, out_r.kind};
endmodule
`default_nettype wire
